// ===== hw/rtl/sha256_byte_stream_hasher_top_macros.svh =====
// assertion helpers used by shabs_ctrl
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH

// condition in this cycle implies consequence in the next cycle
`define SHABS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shabs assertion failed");

// condition implies consequence in the same cycle
`define SHABS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shabs assertion failed");

`endif

// ===== hw/rtl/shabs_pkg.sv =====
package shabs_pkg;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned HASH_WORDS  = 8;
   localparam logic [7:0]  PAD_MARK    = 8'h80;
   localparam logic [5:0]  LEN_POS     = 6'd56;
   localparam logic [5:0]  FILL_LAST   = 6'd63;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         wr_byte;
      byte_sel_type byte_sel;
      logic         init_rounds;
      logic         do_round;
      logic         fold_hash;
      logic         out_advance;
      logic         restart;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
      logic       word_last;
   } dp_status_type;

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] IV_TABLE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
      ror32 = (v >> s) | (v << (32 - s));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] v);
      big_sigma0 = ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] v);
      big_sigma1 = ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] v);
      small_sigma0 = ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] v);
      small_sigma1 = ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
   endfunction

endpackage

// ===== hw/rtl/shabs_dp.sv =====
module shabs_dp
   import shabs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  logic [7:0]    data_byte,
   output dp_status_type status,
   output logic [31:0]   digest_word,
   output logic [2:0]    word_number
);

   logic [31:0] hash_ff [HASH_WORDS];
   logic [31:0] hash_in [HASH_WORDS];
   logic [31:0] st_ff   [HASH_WORDS];
   logic [31:0] st_in   [HASH_WORDS];
   logic [31:0] w_ff    [BLOCK_WORDS];
   logic [31:0] w_in    [BLOCK_WORDS];
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  word_ff, word_in;
   logic [63:0] bits_ff, bits_in;
   logic [7:0]  wr_val;
   logic [31:0] t1, t2, w_next;

   // byte to store at the fill position
   always_comb begin
      unique case (cmd.byte_sel)
         SEL_DATA: wr_val = data_byte;
         SEL_MARK: wr_val = PAD_MARK;
         SEL_ZERO: wr_val = 8'h00;
         SEL_LEN:  wr_val = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];
         default:  wr_val = 8'h00;
      endcase
   end

   always_comb begin
      t1 = st_ff[7] + big_sigma1(st_ff[4])
         + ((st_ff[4] & st_ff[5]) ^ (~st_ff[4] & st_ff[6]))
         + K_TABLE[round_ff] + w_ff[0];
      t2 = big_sigma0(st_ff[0])
         + ((st_ff[0] & st_ff[1]) ^ (st_ff[0] & st_ff[2]) ^ (st_ff[1] & st_ff[2]));
      w_next = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];
   end

   always_comb begin
      w_in     = w_ff;
      st_in    = st_ff;
      hash_in  = hash_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      word_in  = word_ff;
      bits_in  = bits_ff;
      if (cmd.wr_byte) begin
         w_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = wr_val;
         fill_in = fill_ff + 6'd1;
         if (cmd.byte_sel == SEL_DATA) begin
            bits_in = bits_ff + 64'd8;
         end
      end
      if (cmd.init_rounds) begin
         st_in    = hash_ff;
         round_in = '0;
      end
      if (cmd.do_round) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[BLOCK_WORDS - 1] = w_next;
         for (int i = 1; i < HASH_WORDS; i++) begin
            st_in[i] = st_ff[i - 1];
         end
         st_in[0] = t1 + t2;
         st_in[4] = st_ff[3] + t1;
         round_in = round_ff + 6'd1;
      end
      if (cmd.fold_hash) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_in[i] = hash_ff[i] + st_ff[i];
         end
      end
      if (cmd.out_advance) begin
         word_in = word_ff + 3'd1;
      end
      if (cmd.restart) begin
         hash_in = IV_TABLE;
         bits_in = '0;
         word_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff  <= w_in;
      st_ff <= st_in;
      if (reset) begin
         hash_ff  <= IV_TABLE;
         fill_ff  <= '0;
         round_ff <= '0;
         word_ff  <= '0;
         bits_ff  <= '0;
      end else begin
         hash_ff  <= hash_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         word_ff  <= word_in;
         bits_ff  <= bits_in;
      end
   end

   assign status.fill       = fill_ff;
   assign status.round_last = (round_ff == 6'd63);
   assign status.word_last  = (word_ff == 3'd7);
   assign digest_word       = hash_ff[word_ff];
   assign word_number       = word_ff;

endmodule

// ===== hw/rtl/shabs_ctrl.sv =====
module shabs_ctrl
   import shabs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          byte_present,
   input  logic          end_of_message,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic pend_ff, pend_in;
   logic mark_ff, mark_in;
   logic len_ok_ff, len_ok_in;
   logic req_hs, rsp_hs;

   assign req_hs = req_tvalid & req_tready;
   assign rsp_hs = rsp_tvalid & rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_hs) begin
               if (byte_present && status.fill == FILL_LAST) begin
                  state_in = ST_LOAD;
               end else if (end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (status.fill == FILL_LAST) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:  state_in = ST_ROUND;
         ST_ROUND: begin
            if (status.round_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (len_ok_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_hs && status.word_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and padding flags
   always_comb begin
      cmd        = '0;
      cmd.byte_sel = SEL_DATA;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      pend_in    = pend_ff;
      mark_in    = mark_ff;
      len_ok_in  = len_ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            mark_in    = 1'b0;
            len_ok_in  = 1'b0;
            if (req_hs) begin
               cmd.wr_byte = byte_present;
               pend_in     = end_of_message;
            end
         end
         ST_PAD: begin
            cmd.wr_byte = 1'b1;
            mark_in     = 1'b1;
            if (!mark_ff) begin
               cmd.byte_sel = SEL_MARK;
               // room left for the length field in this block
               if (status.fill < LEN_POS) begin
                  len_ok_in = 1'b1;
               end
            end else if (len_ok_ff && status.fill >= LEN_POS) begin
               cmd.byte_sel = SEL_LEN;
            end else begin
               cmd.byte_sel = SEL_ZERO;
            end
         end
         ST_LOAD:  cmd.init_rounds = 1'b1;
         ST_ROUND: cmd.do_round    = 1'b1;
         ST_FOLD: begin
            cmd.fold_hash = 1'b1;
            if (pend_ff) begin
               len_ok_in = 1'b1;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_hs) begin
               cmd.out_advance = 1'b1;
               if (status.word_last) begin
                  cmd.restart = 1'b1;
                  pend_in     = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_ff   <= 1'b0;
         mark_ff   <= 1'b0;
         len_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         mark_ff   <= mark_in;
         len_ok_ff <= len_ok_in;
      end
   end

`include "sha256_byte_stream_hasher_top_macros.svh"

   `SHABS_ASSERT_NEXT(a_load_round, clock, reset, state_ff == ST_LOAD, state_ff == ST_ROUND)
   `SHABS_ASSERT_NEXT(a_round_fold, clock, reset,
      state_ff == ST_ROUND && status.round_last, state_ff == ST_FOLD)
   `SHABS_ASSERT_NEXT(a_pad_full, clock, reset,
      state_ff == ST_PAD && status.fill == FILL_LAST, state_ff == ST_LOAD)
   `SHABS_ASSERT_SAME(a_out_len, clock, reset, state_ff == ST_OUT, pend_ff && len_ok_ff)

endmodule

// ===== hw/rtl/sha256_byte_stream_hasher_top.sv =====
// channel | dir | tdata                          | tuser        | tlast
// req     | in  | data_byte[7:0]                 | byte_present | end_of_message
// rsp     | out | digest_word[31:0], word_number | -            | final_word
//
// message bytes are taken one per cycle while req_tready is high; a full 64-byte block then
// runs state load, 64 rounds of the single round unit and hash fold
// a finishing transfer adds the padding bytes at one per cycle, one or two
// compressions, and eight digest transfers
// synchronous active-high reset restores the initial hash, empty block and zero length
// req_tready is high only while idle; a stalled rsp holds the current digest word
module sha256_byte_stream_hasher_top
   import shabs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_number, rest zero
   output logic        rsp_tlast    // final_word
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [31:0]   digest_word;
   logic [2:0]    word_number;

   // sequencing of byte intake, padding, rounds and digest readout
   shabs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .byte_present   (req_tuser),
      .end_of_message (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .status         (status),
      .cmd            (cmd)
   );

   // block words, message schedule, round unit and hash state
   shabs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_tdata),
      .status      (status),
      .digest_word (digest_word),
      .word_number (word_number)
   );

   // digest word packed with its position
   assign rsp_tdata = {5'b00000, word_number, digest_word};
   assign rsp_tlast = status.word_last;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

// scoreboard: software sha-256 over the accepted byte stream, queue of digest words
class digest_scoreboard;
   bit [31:0] hash_state [8];
   bit [7:0]  block_buf [64];
   int unsigned fill_count;
   bit [63:0] bit_count;
   bit [31:0] digest_queue [$];
   int unsigned error_count;
   int unsigned words_checked;
   int unsigned messages_done;
   int unsigned word_seen;

   function new();
      restart();
      error_count = 0;
      words_checked = 0;
      messages_done = 0;
      word_seen = 0;
   endfunction

   function void restart();
      foreach (hash_state[i]) hash_state[i] = shabs_pkg::IV_TABLE[i];
      fill_count = 0;
      bit_count = 0;
   endfunction

   function bit [31:0] rotr(bit [31:0] v, int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   function void compress();
      bit [31:0] w [64];
      bit [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 16; t++)
         w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
      for (int t = 16; t < 64; t++)
         w[t] = w[t-16] + w[t-7]
              + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
              + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
      {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
         hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
      for (int t = 0; t < 64; t++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + shabs_pkg::K_TABLE[t] + w[t];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endfunction

   // note an accepted request transfer
   function void note_byte(bit [7:0] data, bit present, bit finish);
      int unsigned i;
      if (present) begin
         block_buf[fill_count] = data;
         fill_count++;
         bit_count += 8;
         if (fill_count == 64) begin
            compress();
            fill_count = 0;
         end
      end
      if (!finish) return;
      i = fill_count;
      block_buf[i++] = shabs_pkg::PAD_MARK;
      if (i > 56) begin
         while (i < 64) block_buf[i++] = 8'h00;
         compress();
         i = 0;
      end
      while (i < 56) block_buf[i++] = 8'h00;
      for (int k = 0; k < 8; k++) block_buf[63-k] = bit_count[8*k +: 8];
      compress();
      foreach (hash_state[k]) digest_queue = {digest_queue, hash_state[k]};
      messages_done++;
      restart();
   endfunction

   // check one accepted response transfer
   task check_word(bit [39:0] tdata, bit tlast);
      bit [31:0] want;
      bit [2:0] pos;
      if (digest_queue.size() == 0) begin
         report_error($sformatf("unexpected digest word %h", tdata[31:0]));
         return;
      end
      pos = 3'(word_seen % 8);
      want = digest_queue.pop_front();
      word_seen++;
      words_checked++;
      if (tdata[31:0] !== want)
         report_error($sformatf("word %0d got %h want %h", pos, tdata[31:0], want));
      if (tdata[34:32] !== pos)
         report_error($sformatf("word number got %0d want %0d", tdata[34:32], pos));
      if (tdata[39:35] !== 5'd0)
         report_error("nonzero pad bits in rsp_tdata");
      if (tlast !== (pos == 3'd7))
         report_error($sformatf("final flag %b on word %0d", tlast, pos));
   endtask

   task report_error(string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask
endclass

module testbench;
   import shabs_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   digest_scoreboard sb = new();
   bit  calm_phase = 1'b0;    // no idling at the end of the run
   int  idle_cycles = 0;
   int  bytes_sent = 0;

   always #5 clock = ~clock;

   sha256_byte_stream_hasher_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // response side: check every transfer, stall in random bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tdata, rsp_tlast);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", idle_cycles);
         $display("testbench: errors");
         $finish;
      end
   end

   // one request transfer, with an optional random gap in front
   task automatic send_item(input bit [7:0] data, input bit present, input bit finish);
      int gap;
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= present;
      req_tlast  <= finish;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(data, present, finish);
      if (present) bytes_sent++;
   endtask

   // message of given length with random bytes; absent-byte items mixed in
   task automatic send_message(input int len, input bit end_bare);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (i == len - 1) && !end_bare);
      end
      if (end_bare || len == 0)
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, "abc", byte extremes, padding boundaries
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);          // ignored item, nothing added
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'haa, 1'b0, 1'b1);          // end without byte after data
      send_item(8'h55, 1'b1, 1'b1);

      // extra padding block, then a full block finished on its last byte
      send_message(56, 1'b0);
      send_message(64, 1'b0);
      for (int m = 0; m < 3; m++)
         send_message($urandom_range(0, 8), $urandom_range(0, 1));
      calm_phase = 1'b1;
      send_message($urandom_range(1, 8), 1'b0);
      send_message(0, 1'b1);
      req_tvalid <= 1'b0;

      while (sb.digest_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d messages, %0d message bytes, %0d digest words checked",
               sb.messages_done, bytes_sent, sb.words_checked);
      if (sb.error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/shabs_pkg.sv
hw/rtl/shabs_dp.sv
hw/rtl/shabs_ctrl.sv
hw/rtl/sha256_byte_stream_hasher_top.sv
sim/testbench.sv
